[hw/rtl/min_max_normalizer_core_assert.svh]
// Assertion macros shared by the min-max normalizer RTL.
`ifndef MIN_MAX_NORMALIZER_CORE_ASSERT_SVH
`define MIN_MAX_NORMALIZER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define MMN_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define MMN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Condition that must never hold.
`define MMN_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`else

`define MMN_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define MMN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`define MMN_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

[hw/rtl/mmn_pkg.sv]
// Types and constants of the min-max normalizer.
`timescale 1ns / 1ps

package mmn_pkg;

	// Input item: one sample and the end-of-series mark.
	typedef struct packed {
		logic signed [15:0] sample;
		logic               is_last;
	} sample_item_t;

	// Result item: one normalized sample in signed Q24.8.
	typedef struct packed {
		logic signed [31:0] norm_value;
		logic               end_of_series;
		logic               overflowed;
	} result_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_OUT_HIGH = 2'd0,
		REG_OUT_LOW  = 2'd1,
		REG_EPSILON  = 2'd2,
		REG_UNUSED   = 2'd3
	} cfg_reg_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_LOAD,
		S_RANGE,
		S_READ,
		S_MUL,
		S_ABS,
		S_DIV,
		S_OUT
	} mmn_state_t;

	localparam int DIV_STEPS = 32;
	localparam int STEP_W    = 5;

	localparam logic signed [15:0] OUT_HIGH_RST = 16'sd256;
	localparam logic signed [15:0] OUT_LOW_RST  = 16'sd0;
	localparam logic        [15:0] EPSILON_RST  = 16'd0;
	localparam logic signed [15:0] SAMPLE_MAX   = 16'sh7FFF;
	localparam logic signed [15:0] SAMPLE_MIN   = 16'sh8000;

	localparam logic signed [33:0] ACC_MAX = 34'sh0_7FFF_FFFF;
	localparam logic signed [33:0] ACC_MIN = -34'sh0_8000_0000;

endpackage

[hw/rtl/min_max_normalizer_core.sv]
// Min-max normalizer: sample store, range tracking and a shared serial divider.
// Loading accepts one sample per cycle; busy stays low until the last sample is taken.
// After the last sample each stored sample in turn is read, multiplied and divided
// by the 32-step radix-2 divider shared by all samples; no new series loads meanwhile.
// The receiver cannot stall; each result is shown for one cycle with result_strobe.
// Reset clears the sequencer, configuration and series state; the sample store and datapath are not cleared.
`timescale 1ns / 1ps

`include "min_max_normalizer_core_assert.svh"

module min_max_normalizer_core
	import mmn_pkg::*;
#(
	parameter int MAX_LEN = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  sample_item_t item,
	output logic         result_strobe,
	output result_t      result,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_LEN);
	localparam logic [CW-1:0] ONE_COUNT  = CW'(1);

	mmn_state_t state_q, state_d;

	logic signed [15:0] out_high_q, out_low_q;
	logic        [15:0] epsilon_q;

	logic [CW-1:0]      fill_q, idx_q;
	logic signed [15:0] min_q, max_q;
	logic               drop_q;
	logic [STEP_W-1:0]  step_q;

	logic signed [15:0] mem [MAX_LEN];
	logic signed [15:0] rd_q;
	logic        [15:0] div_q;
	logic signed [33:0] prod_q;
	logic        [31:0] dvd_q;
	logic        [15:0] rem_q;
	logic               neg_q;
	logic               strobe_q;
	result_t            result_q;

	logic               accept;
	logic               store_en;
	logic               last_out;
	logic        [15:0] range_w;
	logic signed [16:0] span_w;
	logic        [15:0] diff_w;
	logic        [16:0] trial_w;
	logic               fit_w;
	logic signed [33:0] quot_w;
	logic signed [33:0] acc_w;
	logic signed [31:0] sat_w;

	assign accept    = start && !busy;
	assign store_en  = accept && (fill_q < FULL_COUNT);
	assign busy      = (state_q != S_LOAD);
	assign cfg_ready = 1'b1;
	assign last_out  = ((idx_q + ONE_COUNT) == fill_q);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: load, set up the range, then per stored sample read, multiply, take magnitude, divide and emit.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_LOAD: begin
				if (accept && item.is_last) state_d = S_RANGE;
			end
			S_RANGE: state_d = S_READ;
			S_READ:  state_d = S_MUL;
			S_MUL:   state_d = S_ABS;
			S_ABS:   state_d = S_DIV;
			S_DIV: begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) state_d = S_OUT;
			end
			S_OUT: begin
				state_d = last_out ? S_LOAD : S_READ;
			end
			default: state_d = S_LOAD;
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_high_q <= OUT_HIGH_RST;
			out_low_q  <= OUT_LOW_RST;
			epsilon_q  <= EPSILON_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_OUT_HIGH: out_high_q <= cfg_data;
				REG_OUT_LOW:  out_low_q  <= cfg_data;
				REG_EPSILON:  epsilon_q  <= cfg_data;
				default:      ;
			endcase
		end
	end

	// Series state: fill count, running extremes, drop flag, emit index, divider step, result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			min_q    <= SAMPLE_MAX;
			max_q    <= SAMPLE_MIN;
			drop_q   <= 1'b0;
			idx_q    <= '0;
			step_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (accept) begin
				if (store_en) begin
					fill_q <= fill_q + ONE_COUNT;
					if (item.sample < min_q) min_q <= item.sample;
					if (item.sample > max_q) max_q <= item.sample;
				end else begin
					drop_q <= 1'b1;
				end
			end
			if (state_q == S_RANGE) idx_q <= '0;
			if (state_q == S_ABS) step_q <= '0;
			if (state_q == S_DIV) step_q <= step_q + STEP_W'(1);
			if (state_q == S_OUT) begin
				strobe_q <= 1'b1;
				idx_q    <= idx_q + ONE_COUNT;
				if (last_out) begin
					fill_q <= '0;
					min_q  <= SAMPLE_MAX;
					max_q  <= SAMPLE_MIN;
					drop_q <= 1'b0;
				end
			end
		end
	end

	// Sample store with a registered read port.
	always_ff @(posedge clk) begin
		if (store_en) mem[fill_q[AW-1:0]] <= item.sample;
		if (state_q == S_READ) rd_q <= mem[idx_q[AW-1:0]];
	end

	// Range, offset and span.
	assign range_w = 16'(17'(max_q) - 17'(min_q));
	assign span_w  = 17'(out_high_q) - 17'(out_low_q);
	assign diff_w  = 16'(17'(rd_q) - 17'(min_q));

	// One restoring divider step: shift in the next dividend bit and try to subtract.
	assign trial_w = {rem_q, dvd_q[31]};
	assign fit_w   = (trial_w >= {1'b0, div_q});

	// Floored quotient, offset and saturation.
	always_comb begin
		quot_w = $signed({2'b00, dvd_q});
		if (neg_q) begin
			quot_w = -($signed({2'b00, dvd_q}) + ((rem_q != '0) ? 34'sd1 : 34'sd0));
		end
		acc_w = 34'(out_low_q) + quot_w;
		if (acc_w > ACC_MAX) begin
			sat_w = ACC_MAX[31:0];
		end else if (acc_w < ACC_MIN) begin
			sat_w = ACC_MIN[31:0];
		end else begin
			sat_w = acc_w[31:0];
		end
	end

	// Arithmetic datapath: divisor, product, magnitude, divide, result.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_RANGE: begin
				div_q <= ({1'b0, epsilon_q} >= {1'b0, range_w}) ? 16'd1 : range_w;
			end
			S_MUL: begin
				prod_q <= 34'(span_w) * 34'($signed({1'b0, diff_w}));
			end
			S_ABS: begin
				neg_q <= prod_q[33];
				dvd_q <= prod_q[33] ? 32'(-prod_q) : prod_q[31:0];
				rem_q <= '0;
			end
			S_DIV: begin
				dvd_q <= {dvd_q[30:0], fit_w};
				rem_q <= fit_w ? 16'(trial_w - {1'b0, div_q}) : trial_w[15:0];
			end
			S_OUT: begin
				result_q.norm_value    <= sat_w;
				result_q.end_of_series <= last_out;
				result_q.overflowed    <= drop_q;
			end
			default: ;
		endcase
	end

	assign result_strobe = strobe_q;
	assign result        = result_q;

	`MMN_ASSERT_IMPL(a_strobe_mid_series, clk, arst_n, result_strobe && !result.end_of_series, busy, "result mid-series while idle")
	`MMN_ASSERT_NEXT(a_last_starts_emit, clk, arst_n, accept && item.is_last, busy, "last sample did not start emit pass")
	`MMN_ASSERT_NEVER(a_fill_bound, clk, arst_n, fill_q > FULL_COUNT, "fill count beyond capacity")
	`MMN_ASSERT_IMPL(a_divisor_nonzero, clk, arst_n, state_q == S_DIV, div_q != 16'd0, "divide by zero")
	`MMN_ASSERT_IMPL(a_emit_nonempty, clk, arst_n, state_q == S_READ, idx_q < fill_q, "emit index beyond stored samples")

endmodule
